@@ rtl/srq_pkg.sv @@
// Package: record, item and result types, op and status codes for the sortable ring queue.
`default_nettype none

package srq_pkg;

    localparam int CODE_HALF_W = 40;
    localparam int CODE_BITS   = 2 * CODE_HALF_W;
    localparam int TAG_W       = 32;
    localparam int OCC_W       = 4;

    typedef logic [1:0] t_op;
    localparam t_op OP_ENQ  = 2'd0;
    localparam t_op OP_DEQ  = 2'd1;
    localparam t_op OP_SORT = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        t_op                      op;
        logic [CODE_HALF_W-1:0]   code_hi;
        logic [CODE_HALF_W-1:0]   code_lo;
        logic signed [TAG_W-1:0]  tag_value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic [CODE_HALF_W-1:0]   out_code_hi;
        logic [CODE_HALF_W-1:0]   out_code_lo;
        logic signed [TAG_W-1:0]  out_tag_value;
        logic [OCC_W-1:0]         occupancy;
    } t_out;

    typedef struct packed {
        logic [CODE_HALF_W-1:0]   code_hi;
        logic [CODE_HALF_W-1:0]   code_lo;
        logic signed [TAG_W-1:0]  tag;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

`default_nettype wire

@@ rtl/sortable_ring_queue_unit.sv @@
// Top level: ring queue of records with an in-place bubble sort sequencer.
// Enqueue, failed dequeue, no-op and sort of fewer than two records: result next cycle.
// Dequeue: one RAM read, busy for one cycle.
// Sort of n records: one RAM read and one compare per step over n-1 bubble passes;
// busy throughout, result strobe the cycle after.
// Synchronous active-low reset empties the queue; stored records are not cleared.
`default_nettype none

module sortable_ring_queue_unit #(
    parameter int QUEUE_DEPTH = 8,
    parameter int CODE_CHARS  = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire srq_pkg::t_in  i_item,
    output logic               busy,
    output logic               o_done,
    output srq_pkg::t_out      o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEQ  = 5'b00010,
        S_LOAD = 5'b00100,
        S_WALK = 5'b01000,
        S_LAST = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]     r_left, n_left;
    logic [CW-1:0]     r_pass_len, n_pass_len;
    srq_pkg::t_rec     r_carry, n_carry;
    logic              r_done, n_done;
    srq_pkg::t_out     r_out, n_out;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    srq_pkg::t_rec     wr_data;
    logic [AW-1:0]     rd_addr;
    srq_pkg::t_rec     rd_data;
    logic              less;

    srq_ram #(
        .WIDTH (srq_pkg::REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    srq_cmp #(
        .CODE_CHARS (CODE_CHARS)
    ) u_cmp (
        .i_a    (rd_data),
        .i_b    (r_carry),
        .o_less (less)
    );

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_left     = r_left;
        n_pass_len = r_pass_len;
        n_carry    = r_carry;
        n_done     = 1'b0;
        n_out      = r_out;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        wr_data    = '{code_hi: i_item.code_hi, code_lo: i_item.code_lo,
                       tag: i_item.tag_value};
        rd_addr    = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_out        = '0;
                    n_out.status = srq_pkg::ST_DONE;
                    unique case (i_item.op)
                        srq_pkg::OP_ENQ: begin
                            n_done = 1'b1;
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_out.status = srq_pkg::ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_tail  = ptr_inc(r_tail);
                                n_count = r_count + 1'b1;
                            end
                        end
                        srq_pkg::OP_DEQ: begin
                            if (r_count == '0) begin
                                n_done       = 1'b1;
                                n_out.status = srq_pkg::ST_UNDERFLOW;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        srq_pkg::OP_SORT: begin
                            if (r_count < CW'(2)) begin
                                n_done = 1'b1;
                            end else begin
                                // head is being read now; next read is head+1
                                n_pass_len = r_count;
                                n_left     = r_count - 1'b1;
                                n_ptr      = ptr_inc(r_head);
                                n_wr_ptr   = r_head;
                                n_state    = S_LOAD;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_done            = 1'b1;
                n_out.out_code_hi = rd_data.code_hi;
                n_out.out_code_lo = rd_data.code_lo;
                n_out.out_tag_value = rd_data.tag;
                n_head            = ptr_inc(r_head);
                n_count           = r_count - 1'b1;
                n_state           = S_IDLE;
            end
            S_LOAD: begin
                n_carry = rd_data;
                rd_addr = r_ptr;
                n_ptr   = ptr_inc(r_ptr);
                n_state = S_WALK;
            end
            S_WALK: begin
                // strict compare keeps equal keys in order
                wr_en    = 1'b1;
                wr_addr  = r_wr_ptr;
                wr_data  = less ? rd_data : r_carry;
                n_carry  = less ? r_carry : rd_data;
                n_wr_ptr = ptr_inc(r_wr_ptr);
                rd_addr  = r_ptr;
                n_ptr    = ptr_inc(r_ptr);
                n_left   = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                wr_en      = 1'b1;
                wr_addr    = r_wr_ptr;
                wr_data    = r_carry;
                n_pass_len = r_pass_len - 1'b1;
                if (r_pass_len > CW'(2)) begin
                    // next pass starts at head, one entry shorter
                    rd_addr  = r_head;
                    n_ptr    = ptr_inc(r_head);
                    n_wr_ptr = r_head;
                    n_left   = r_pass_len - CW'(2);
                    n_state  = S_LOAD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.occupancy = srq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_wr_ptr   <= n_wr_ptr;
        r_left     <= n_left;
        r_pass_len <= n_pass_len;
        r_carry    <= n_carry;
        r_out      <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.occupancy == srq_pkg::OCC_W'(r_count)))
        else $error("reported occupancy differs from entry count");

    a_sort_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == srq_pkg::OP_SORT) && (r_count > CW'(1)))
        |=> (busy && !o_done))
        else $error("sort of several records did not enter the sequencer");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.op == srq_pkg::OP_DEQ) && (r_count == '0))
        |=> (o_done && (o_result.status == srq_pkg::ST_UNDERFLOW)
             && (o_result.occupancy == '0)))
        else $error("empty dequeue did not report underflow");

endmodule

`default_nettype wire

@@ rtl/srq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/srq_cmp.sv @@
// Record key comparator: code characters left to right, then signed tag.
`default_nettype none

module srq_cmp #(
    parameter int CODE_CHARS = 10
) (
    input  wire srq_pkg::t_rec i_a,
    input  wire srq_pkg::t_rec i_b,
    output logic               o_less
);

    // characters past CODE_CHARS sit in the low bytes and are shifted out
    localparam int DROP = srq_pkg::CODE_BITS - CODE_CHARS * 8;

    logic [srq_pkg::CODE_BITS-1:0] key_a;
    logic [srq_pkg::CODE_BITS-1:0] key_b;

    assign key_a  = {i_a.code_hi, i_a.code_lo} >> DROP;
    assign key_b  = {i_b.code_hi, i_b.code_lo} >> DROP;
    assign o_less = (key_a < key_b) || ((key_a == key_b) && (i_a.tag < i_b.tag));

endmodule

`default_nettype wire

@@ dv/sortable_ring_queue_unit_tb.sv @@
// Testbench for the sortable ring queue: random and directed items checked against a queue tracker.
module sortable_ring_queue_unit_tb;
    import srq_pkg::*;

    localparam int DEPTH      = 8;
    localparam int SORT_CHARS = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 1200;

    // op code 3 has no meaning: the block reports its occupancy and nothing else
    localparam t_op OP_NONE = 2'd3;

    class ring_queue_tracker;
        t_rec        slots [DEPTH];
        int          head;
        int          tail;
        int          count;
        t_out        due_results [$];
        int          errors;

        function new();
            head   = 0;
            tail   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function bit key_before(t_rec a, t_rec b);
            logic [CODE_BITS-1:0] ca;
            logic [CODE_BITS-1:0] cb;
            ca = {a.code_hi, a.code_lo};
            cb = {b.code_hi, b.code_lo};
            for (int k = 0; k < SORT_CHARS; k++) begin
                if (ca[CODE_BITS-1-8*k -: 8] != cb[CODE_BITS-1-8*k -: 8])
                    return ca[CODE_BITS-1-8*k -: 8] < cb[CODE_BITS-1-8*k -: 8];
            end
            return $signed(a.tag) < $signed(b.tag);
        endfunction

        // stable insertion sort of the live records, head first
        function void sort_live();
            t_rec line_up [DEPTH];
            t_rec moving;
            int   j;
            for (int i = 0; i < count; i++)
                line_up[i] = slots[(head + i) % DEPTH];
            for (int i = 1; i < count; i++) begin
                moving = line_up[i];
                j = i;
                while (j > 0 && key_before(moving, line_up[j-1])) begin
                    line_up[j] = line_up[j-1];
                    j--;
                end
                line_up[j] = moving;
            end
            for (int i = 0; i < count; i++)
                slots[(head + i) % DEPTH] = line_up[i];
        endfunction

        function void note_item(t_in it);
            t_out r;
            r = '0;
            r.status = ST_DONE;
            case (it.op)
                OP_ENQ: begin
                    if (count >= DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        slots[tail].code_hi = it.code_hi;
                        slots[tail].code_lo = it.code_lo;
                        slots[tail].tag     = it.tag_value;
                        tail = (tail + 1) % DEPTH;
                        count++;
                    end
                end
                OP_DEQ: begin
                    if (count == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        r.out_code_hi   = slots[head].code_hi;
                        r.out_code_lo   = slots[head].code_lo;
                        r.out_tag_value = slots[head].tag;
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                end
                OP_SORT: sort_live();
                default: ;
            endcase
            r.occupancy = count[OCC_W-1:0];
            due_results.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                $error("result with no item outstanding: %p", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.out_code_hi !== want.out_code_hi) begin
                $error("out_code_hi: expected %h, got %h", want.out_code_hi, got.out_code_hi);
                errors++;
            end
            if (got.out_code_lo !== want.out_code_lo) begin
                $error("out_code_lo: expected %h, got %h", want.out_code_lo, got.out_code_lo);
                errors++;
            end
            if (got.out_tag_value !== want.out_tag_value) begin
                $error("out_tag_value: expected %0d, got %0d",
                       want.out_tag_value, got.out_tag_value);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    t_in    i_item  = '0;
    logic   busy;
    logic   o_done;
    t_out   o_result;

    ring_queue_tracker tracker = new();
    int unsigned       idle_cycles = 0;
    bit                burst = 1'b0;
    logic [CODE_HALF_W-1:0] last_hi = '0;
    logic [CODE_HALF_W-1:0] last_lo = '0;

    sortable_ring_queue_unit #(
        .QUEUE_DEPTH (DEPTH),
        .CODE_CHARS  (SORT_CHARS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_result(o_result);
    end

    // watchdog: cycles with neither an item nor a result accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [CODE_HALF_W-1:0] wide_rand();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[CODE_HALF_W-1:0];
    endfunction

    // narrow alphabet so that shared prefixes and equal codes turn up often
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'h41;
            2: return 8'h42;
            3: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_tag();
        if ($urandom_range(0, 1))
            return $urandom();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_in make_item(t_op op, logic [CODE_HALF_W-1:0] hi,
                                      logic [CODE_HALF_W-1:0] lo, logic [31:0] tag);
        t_in it;
        it.op        = op;
        it.code_hi   = hi;
        it.code_lo   = lo;
        it.tag_value = tag;
        return it;
    endfunction

    function automatic t_in random_item(t_op op);
        logic [CODE_HALF_W-1:0] hi;
        logic [CODE_HALF_W-1:0] lo;
        int                     mode;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            hi = wide_rand();
            lo = wide_rand();
        end else if (mode < 8) begin
            for (int k = 0; k < 5; k++) begin
                hi[8*k +: 8] = pick_char();
                lo[8*k +: 8] = pick_char();
            end
        end else begin
            hi = last_hi;
            lo = last_lo;
        end
        if (op == OP_ENQ) begin
            last_hi = hi;
            last_lo = lo;
        end
        return make_item(op, hi, lo, pick_tag());
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // called at a falling edge; returns at a falling edge with start still high
    // unless a gap followed
    task automatic send(t_in it, int gap);
        start  <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        tracker.note_item(it);
        @(negedge i_clk);
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= random_item(t_op'($urandom_range(0, 3)));
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        t_op op;
        bit  filling;
        int  r;
        int  run_left;

        filling  = 1'b1;
        run_left = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue corner cases
        send(make_item(OP_DEQ, '0, '0, '0), 0);
        send(make_item(OP_NONE, '1, '1, '1), pick_gap());
        send(make_item(OP_SORT, '0, '0, '0), 0);
        // fill: extremes, differences at first and last character, equal codes
        send(make_item(OP_ENQ, '1, '1, 32'h7FFF_FFFF), 0);
        send(make_item(OP_ENQ, '0, '0, 32'h8000_0000), 0);
        send(make_item(OP_ENQ, 40'h4142434445, 40'h4647484949, 32'd5), pick_gap());
        send(make_item(OP_ENQ, 40'h4142434445, 40'h4647484948, 32'd9), 0);
        send(make_item(OP_ENQ, 40'h4142434445, 40'h4647484948, 32'hFFFF_FFFF), 0);
        send(make_item(OP_ENQ, 40'h4142434445, 40'h4647484948, 32'd1), 0);
        send(make_item(OP_ENQ, 40'h4042434445, 40'hFFFFFFFFFF, 32'd0), pick_gap());
        send(make_item(OP_ENQ, 40'h8000000000, 40'h0000000000, 32'd0), 0);
        send(make_item(OP_ENQ, 40'h1111111111, 40'h2222222222, 32'd3), 0);
        send(make_item(OP_SORT, '0, '0, '0), 0);
        send(make_item(OP_NONE, '0, '0, '0), 0);
        repeat (3) send(make_item(OP_DEQ, '1, '1, '1), pick_gap());
        // wrap the tail round and sort across the seam
        send(make_item(OP_ENQ, 40'h0000000001, 40'h0, 32'h8000_0000), 0);
        send(make_item(OP_ENQ, 40'h0000000001, 40'h0, 32'h7FFF_FFFF), 0);
        send(make_item(OP_SORT, '0, '0, '0), 0);
        repeat (3) send(make_item(OP_DEQ, '0, '0, '0), 0);
        drain();
        @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (run_left == 0) begin
                filling  = ~filling;
                run_left = $urandom_range(6, 30);
            end
            run_left--;
            if (n % 50 == 0)
                burst = ($urandom_range(0, 9) < 3);
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_NONE;
            else if (r < 15)
                op = OP_SORT;
            else if (filling)
                op = (r < 75) ? OP_ENQ : OP_DEQ;
            else
                op = (r < 40) ? OP_ENQ : OP_DEQ;
            send(random_item(op), pick_gap());
            if (n % 300 == 299) begin
                drain();
                @(negedge i_clk);
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
